>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked, reset-gated property checks reporting through $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/c2d_pkg.sv
// ---------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the integer convolution block.
// ---------------------------------------------------------------------------
package c2d_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_IMAGE_COLS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
    localparam logic [IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

    // item kinds on tuser
    localparam logic FUNC_KERNEL = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    // control handed from the sequencer to every cell
    typedef struct packed {
        logic clear;     // zero the accumulator
        logic issue;     // memory reads for one column step
        logic rd_valid;  // read data present, form product
        logic acc_en;    // add product into accumulator
        logic reduce;    // pass partial sums down the chain
    } cell_ctrl_t;

endpackage

>>> src/c2d_line_store.sv
// ---------------------------------------------------------------------------
// c2d_line_store
// Banked line buffer: one bank per kernel row, all banks read in lockstep.
// ---------------------------------------------------------------------------
module c2d_line_store #(
    parameter int MAX_KERNEL_ROWS = 8,
    parameter int MAX_WIDTH       = 256
) (
    input  logic                                           clk,
    input  logic                                           wr_en,
    input  logic [(MAX_KERNEL_ROWS > 1 ? $clog2(MAX_KERNEL_ROWS) : 1)-1:0] wr_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0]                   wr_col,
    input  logic [c2d_pkg::DATA_W-1:0]                     wr_data,
    input  logic                                           rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]                   rd_col,
    output logic [MAX_KERNEL_ROWS-1:0][c2d_pkg::DATA_W-1:0] rd_data
);

    for (genvar b = 0; b < MAX_KERNEL_ROWS; b++) begin : g_bank
        logic [c2d_pkg::DATA_W-1:0] mem [MAX_WIDTH];
        logic [c2d_pkg::DATA_W-1:0] rdata_reg;

        // one write port, one registered read port per bank
        always_ff @(posedge clk)
        begin
            if (wr_en && (int'(wr_bank) == b))
            begin
                mem[wr_col] <= wr_data;
            end
            if (rd_en)
            begin
                rdata_reg <= mem[rd_col];
            end
        end

        assign rd_data[b] = rdata_reg;
    end

endmodule

>>> src/c2d_cell.sv
// ---------------------------------------------------------------------------
// c2d_cell
// One kernel-row cell: kernel copy, multiplier, accumulator, chain link.
// ---------------------------------------------------------------------------
module c2d_cell #(
    parameter int MAX_KERNEL_ROWS = 8,
    parameter int MAX_KERNEL_COLS = 8,
    parameter int ROW             = 0
) (
    input  logic                                            clk,
    input  c2d_pkg::cell_ctrl_t                             ctrl,
    input  logic                                            kwr_en,
    input  logic [(MAX_KERNEL_ROWS*MAX_KERNEL_COLS > 1 ?
                   $clog2(MAX_KERNEL_ROWS*MAX_KERNEL_COLS) : 1)-1:0] kwr_addr,
    input  logic [c2d_pkg::DATA_W-1:0]                      kwr_data,
    input  logic [$clog2(MAX_KERNEL_ROWS+1)-1:0]            kr,
    input  logic [$clog2(MAX_KERNEL_COLS+1)-1:0]            kc,
    input  logic [$clog2(MAX_KERNEL_COLS+1)-1:0]            step,
    input  logic [(MAX_KERNEL_ROWS > 1 ? $clog2(MAX_KERNEL_ROWS) : 1)-1:0] cur_bank,
    input  logic [MAX_KERNEL_ROWS-1:0][c2d_pkg::DATA_W-1:0] bank_data,
    input  logic [c2d_pkg::DATA_W-1:0]                      sum_in,
    output logic [c2d_pkg::DATA_W-1:0]                      sum_out
);

    localparam int KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int KIDX_W = KDEPTH > 1 ? $clog2(KDEPTH) : 1;
    localparam int BANK_W = MAX_KERNEL_ROWS > 1 ? $clog2(MAX_KERNEL_ROWS) : 1;
    localparam logic HEAD = (ROW == 0);

    logic [c2d_pkg::DATA_W-1:0] kmem [KDEPTH];
    logic [c2d_pkg::DATA_W-1:0] kdata_reg;
    logic [c2d_pkg::DATA_W-1:0] prod_reg;
    logic [c2d_pkg::DATA_W-1:0] prod_next;
    logic [c2d_pkg::DATA_W-1:0] acc_reg;
    logic [c2d_pkg::DATA_W-1:0] acc_next;
    logic [c2d_pkg::DATA_W-1:0] pix;
    logic [KIDX_W-1:0]          krd_addr;
    logic [BANK_W:0]            sel_wide;
    logic [BANK_W-1:0]          sel;
    logic                       active;

    // coefficient of this kernel row, walked from the right-hand end
    assign krd_addr = KIDX_W'(32'(ROW + 1) * 32'(kc) - 32'd1 - 32'(step));

    // line bank holding the image row that meets this kernel row
    always_comb
    begin
        if (int'(cur_bank) >= ROW)
            sel_wide = (BANK_W+1)'(int'(cur_bank) - ROW);
        else
            sel_wide = (BANK_W+1)'(int'(cur_bank) + MAX_KERNEL_ROWS - ROW);
    end
    assign sel    = sel_wide[BANK_W-1:0];
    assign pix    = bank_data[sel];
    assign active = (ROW < int'(kr));

    // kernel copy: broadcast write, registered read
    always_ff @(posedge clk)
    begin
        if (kwr_en)
        begin
            kmem[kwr_addr] <= kwr_data;
        end
        if (ctrl.issue)
        begin
            kdata_reg <= kmem[krd_addr];
        end
    end

    // product, wrapped to 32 bits; rows outside the kernel add nothing
    assign prod_next = active ? (kdata_reg * pix) : '0;

    // accumulate, then shift partial sums towards the head cell
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (ctrl.acc_en)
            acc_next = acc_reg + prod_reg;
        else if (ctrl.reduce)
            acc_next = (HEAD ? acc_reg : '0) + sum_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_valid)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign sum_out = acc_reg;

endmodule

>>> src/conv2d_valid_integer.sv
// ---------------------------------------------------------------------------
// conv2d_valid_integer
// Valid 2-D integer convolution over a row-major pixel stream.
// ---------------------------------------------------------------------------
// Load the kernel row-major with tuser = 0, then stream pixels row-major with
// tuser = 1. A kernel item, or a pixel that does not complete a window, leaves
// the block ready for the next item. A pixel that completes a window holds
// s_tready low while it runs: acceptance of the pixel, one column step per kernel
// column, as every kernel-row cell walks its coefficients against the banked
// line store, a read and multiply drain, a shift of the partial sums down the
// cell chain, and a load of the output register. The output register
// lets the next item enter while a result waits; a result still held there
// stalls the next window at its output load. Sums wrap modulo 2^32; tlast marks
// the result of the final pixel of the image.
module conv2d_valid_integer #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_KERNEL_ROWS = 8,
    parameter int MAX_KERNEL_COLS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [c2d_pkg::IDX_W-1:0]     cfg_index,
    input  logic [c2d_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [c2d_pkg::DATA_W-1:0]    s_tdata,   // [31:0] value
    input  logic [0:0]                    s_tuser,   // [0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [c2d_pkg::DATA_W-1:0]    m_tdata,   // [31:0] result
    output logic                          m_tlast
);

`include "assert_macros.svh"

    localparam int KDEPTH  = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int KIDX_W  = KDEPTH > 1 ? $clog2(KDEPTH) : 1;
    localparam int BANK_W  = MAX_KERNEL_ROWS > 1 ? $clog2(MAX_KERNEL_ROWS) : 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CW_W    = $clog2(MAX_WIDTH + 1);
    localparam int KR_W    = $clog2(MAX_KERNEL_ROWS + 1);
    localparam int KC_W    = $clog2(MAX_KERNEL_COLS + 1);
    localparam int KP_W    = KR_W + KC_W;
    localparam int CNT_MAX = (MAX_KERNEL_COLS > MAX_KERNEL_ROWS ?
                              MAX_KERNEL_COLS : MAX_KERNEL_ROWS) + 2;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam logic [CNT_W-1:0] RED_LAST =
        CNT_W'(MAX_KERNEL_ROWS > 1 ? MAX_KERNEL_ROWS - 2 : 0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_REDUCE,
        ST_DONE
    } state_t;

    state_t st_reg;

    // configuration registers
    logic [8:0]  image_cols_reg;
    logic [15:0] image_rows_reg;
    logic [3:0]  kernel_rows_reg;
    logic [3:0]  kernel_cols_reg;

    // stream position
    logic [KIDX_W-1:0] kidx_reg;
    logic [15:0]       row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [BANK_W-1:0] bank_reg;

    // per-window registers
    logic [COL_W-1:0]  c0_reg;
    logic [BANK_W-1:0] cur_bank_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;
    logic              rd_valid_reg;
    logic              acc_en_reg;

    logic [c2d_pkg::DATA_W-1:0] m_tdata_reg;
    logic                       m_tvalid_reg;
    logic                       m_tlast_reg;

    // derived values
    logic [KR_W-1:0]  kr_eff;
    logic [KC_W-1:0]  kc_eff;
    logic [CW_W-1:0]  cols_eff;
    logic [15:0]      rows_eff;
    logic [KP_W-1:0]  ksize;
    logic [CW_W-1:0]  col_p1;
    logic             accept;
    logic             is_pixel;
    logic             kidx_wrap;
    logic             row_end;
    logic             img_end;
    logic             window;
    logic             out_free;
    logic [COL_W-1:0] rd_col;
    c2d_pkg::cell_ctrl_t ctrl;

    logic [MAX_KERNEL_ROWS-1:0][c2d_pkg::DATA_W-1:0] bank_data;
    logic [c2d_pkg::DATA_W-1:0] sums [MAX_KERNEL_ROWS];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_cols_reg  <= 9'd256;
            image_rows_reg  <= 16'd256;
            kernel_rows_reg <= 4'd3;
            kernel_cols_reg <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                c2d_pkg::CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data[8:0];
                c2d_pkg::CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data[15:0];
                c2d_pkg::CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[3:0];
                c2d_pkg::CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // saturate registers to the supported ranges
    always_comb
    begin
        if (kernel_rows_reg == 4'd0)
            kr_eff = KR_W'(1);
        else if (int'(kernel_rows_reg) > MAX_KERNEL_ROWS)
            kr_eff = KR_W'(MAX_KERNEL_ROWS);
        else
            kr_eff = KR_W'(kernel_rows_reg);

        if (kernel_cols_reg == 4'd0)
            kc_eff = KC_W'(1);
        else if (int'(kernel_cols_reg) > MAX_KERNEL_COLS)
            kc_eff = KC_W'(MAX_KERNEL_COLS);
        else
            kc_eff = KC_W'(kernel_cols_reg);

        if (image_cols_reg == 9'd0)
            cols_eff = CW_W'(1);
        else if (int'(image_cols_reg) > MAX_WIDTH)
            cols_eff = CW_W'(MAX_WIDTH);
        else
            cols_eff = CW_W'(image_cols_reg);

        rows_eff = (image_rows_reg == 16'd0) ? 16'd1 : image_rows_reg;
    end

    // input decode
    assign accept    = s_tvalid && s_tready;
    assign is_pixel  = (s_tuser[0] == c2d_pkg::FUNC_PIXEL);
    assign ksize     = KP_W'(kr_eff) * KP_W'(kc_eff);
    assign kidx_wrap = (32'(kidx_reg) + 32'd1 >= 32'(ksize));
    assign col_p1    = CW_W'(col_reg) + CW_W'(1);
    assign row_end   = (col_p1 >= cols_eff);
    assign img_end   = row_end && (17'(row_reg) + 17'd1 >= 17'(rows_eff));
    assign window    = (17'(row_reg) + 17'd1 >= 17'(kr_eff)) &&
                       (17'(col_p1) >= 17'(kc_eff));
    assign s_tready  = (st_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign rd_col    = c0_reg + COL_W'(cnt_reg);

    // kernel index and image position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kidx_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            bank_reg <= '0;
        end
        else if (accept)
        begin
            if (!is_pixel)
            begin
                kidx_reg <= kidx_wrap ? '0 : kidx_reg + KIDX_W'(1);
            end
            else if (row_end)
            begin
                col_reg <= '0;
                if (img_end)
                begin
                    row_reg  <= '0;
                    bank_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_reg + 16'd1;
                    bank_reg <= (int'(bank_reg) == MAX_KERNEL_ROWS - 1) ?
                                '0 : bank_reg + BANK_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // cell control
    always_comb
    begin
        ctrl.clear    = accept && is_pixel && window;
        ctrl.issue    = (st_reg == ST_RUN);
        ctrl.rd_valid = rd_valid_reg;
        ctrl.acc_en   = acc_en_reg;
        ctrl.reduce   = (st_reg == ST_REDUCE);
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            cnt_reg      <= '0;
            c0_reg       <= '0;
            cur_bank_reg <= '0;
            last_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            acc_en_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctrl.issue;
            acc_en_reg   <= rd_valid_reg;
            // output item taken and no new one loaded in this cycle
            if (m_tready && !(st_reg == ST_DONE && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (ctrl.clear)
                    begin
                        st_reg       <= ST_RUN;
                        cnt_reg      <= '0;
                        c0_reg       <= COL_W'(col_p1 - CW_W'(kc_eff));
                        cur_bank_reg <= bank_reg;
                        last_reg     <= img_end;
                    end
                end
                ST_RUN:
                begin
                    if (cnt_reg == CNT_W'(kc_eff) - CNT_W'(1))
                    begin
                        st_reg  <= ST_DRAIN;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (cnt_reg == CNT_W'(1))
                    begin
                        st_reg  <= (MAX_KERNEL_ROWS > 1) ? ST_REDUCE : ST_DONE;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_REDUCE:
                begin
                    if (cnt_reg == RED_LAST)
                        st_reg <= ST_DONE;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= sums[0];
                        m_tlast_reg  <= last_reg;
                        st_reg       <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // line buffer
    c2d_line_store #(
        .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
        .MAX_WIDTH       (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .wr_en   (accept && is_pixel),
        .wr_bank (bank_reg),
        .wr_col  (col_reg),
        .wr_data (s_tdata),
        .rd_en   (ctrl.issue),
        .rd_col  (rd_col),
        .rd_data (bank_data)
    );

    // chain of kernel-row cells; cell 0 ends up with the full sum
    for (genvar d = 0; d < MAX_KERNEL_ROWS; d++)
    begin : g_cell
        logic [c2d_pkg::DATA_W-1:0] chain_in;

        if (d == MAX_KERNEL_ROWS - 1)
        begin : g_tail
            assign chain_in = '0;
        end
        else
        begin : g_link
            assign chain_in = sums[d+1];
        end

        c2d_cell #(
            .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
            .MAX_KERNEL_COLS (MAX_KERNEL_COLS),
            .ROW             (d)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .kwr_en    (accept && !is_pixel),
            .kwr_addr  (kidx_reg),
            .kwr_data  (s_tdata),
            .kr        (kr_eff),
            .kc        (kc_eff),
            .step      (KC_W'(cnt_reg)),
            .cur_bank  (cur_bank_reg),
            .bank_data (bank_data),
            .sum_in    (chain_in),
            .sum_out   (sums[d])
        );
    end

    // checks on the sequencer
    `ASSERT_CLK(a_kidx_range, 32'(kidx_reg) < KDEPTH, "kernel index out of range")
    `ASSERT_CLK(a_reduce_drained, st_reg != ST_REDUCE || (!rd_valid_reg && !acc_en_reg),
        "chain shift while products still in flight")
    `ASSERT_NEXT(a_done_loads, st_reg == ST_DONE && out_free,
        m_tvalid && st_reg == ST_IDLE, "finished window not delivered")
    `ASSERT_NEXT(a_acc_follows_read, acc_en_reg == 1'b0 || 1'b1,
        acc_en_reg == $past(rd_valid_reg), "accumulate not aligned with read")

endmodule
